// ===== src/desktop_bus_keyboard_device_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DESKTOP_BUS_KEYBOARD_DEVICE_UNIT_ASSERT_SVH
`define DESKTOP_BUS_KEYBOARD_DEVICE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DKB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dkb assertion failed");

// Next-cycle implication, disabled during reset.
`define DKB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dkb assertion failed");

`endif

// ===== src/dkb_pkg.sv =====
package dkb_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 128;

    // command_byte[3:2]
    typedef enum logic [1:0] {
        KIND_MISC   = 2'b00,
        KIND_RSVD   = 2'b01,
        KIND_LISTEN = 2'b10,
        KIND_TALK   = 2'b11
    } cmd_kind_t;

    localparam logic [1:0] REG0 = 2'd0;
    localparam logic [1:0] REG2 = 2'd2;
    localparam logic [1:0] REG3 = 2'd3;

    localparam logic [3:0] FLUSH_NIBBLE    = 4'h1;
    localparam logic [6:0] POWER_KEY       = 7'h7f;
    localparam logic [7:0] FILL_BYTE       = 8'hff;
    localparam logic [7:0] SELF_TEST       = 8'hff;
    localparam logic [7:0] LED_HI          = 8'h00;
    localparam logic [7:0] LED_LO          = 8'h07;
    localparam logic [3:0] DEFAULT_ADDR    = 4'h2;
    localparam logic [1:0] DEFAULT_HANDLER = 2'h1;
    localparam logic [1:0] REPLY_NONE      = 2'd0;
    localparam logic [1:0] REPLY_TWO       = 2'd2;

    // decoded operation of one accepted transaction
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
        logic listen3;
        logic talk2;
        logic talk3;
    } cmd_t;

    // FIFO status toward the reply logic
    typedef struct packed {
        logic       popped;
        logic       pending;
        logic [7:0] data;
    } fifo_stat_t;

endpackage

// ===== src/desktop_bus_keyboard_device_unit.sv =====
// The result of a transaction is strobed on done in the cycle after it is accepted.
// Throughput: one transaction per cycle; busy stays low, since each one is a single FIFO
// push, pop or register update and the head entry is read from the code memory at accept.
// Reset (rst_n, async, active low): FIFO empty, address 2, handler 1, no result strobed.
// The code memory is not cleared; only entries that were pushed are ever popped.
// Results cannot be stalled: each is on the ports for exactly one cycle.
module desktop_bus_keyboard_device_unit
#(
    parameter int FIFO_DEPTH = dkb_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [6:0] key_code,
    input  logic       key_released,
    input  logic [7:0] command_byte,
    input  logic [7:0] first_argument,
    input  logic [7:0] second_argument,
    output logic       done,
    output logic [1:0] reply_length,
    output logic [7:0] reply_first,
    output logic [7:0] reply_second,
    output logic       data_pending
);

    dkb_pkg::cmd_t       cmd;
    dkb_pkg::fifo_stat_t stat;

    logic       accept;
    logic       done_reg, done_next;
    logic [1:0] len_reg, len_next;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic [3:0] addr_reg, addr_next;
    logic [1:0] handler_reg, handler_next;
    logic       power_key;

    // every cycle is open for a new transaction
    assign busy   = 1'b0;
    assign accept = start && !busy;

    dkb_cmd_decode u_decode
    (
        .valid        (accept),
        .action       (action),
        .command_byte (command_byte),
        .cmd          (cmd)
    );

    dkb_code_fifo
    #(
        .FIFO_DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .wr_data ({key_released, key_code}),
        .stat    (stat)
    );

    // Register replies and listen-3 updates. Pop replies come from the FIFO read data.
    always_comb
    begin
        done_next    = accept;
        len_next     = dkb_pkg::REPLY_NONE;
        b0_next      = '0;
        b1_next      = '0;
        addr_next    = addr_reg;
        handler_next = handler_reg;
        if (cmd.talk2)
        begin
            len_next = dkb_pkg::REPLY_TWO;
            b0_next  = dkb_pkg::LED_HI;
            b1_next  = dkb_pkg::LED_LO;
        end
        else if (cmd.talk3)
        begin
            len_next = dkb_pkg::REPLY_TWO;
            b0_next  = {4'b0, addr_reg};
            b1_next  = {6'b0, handler_reg};
        end
        else if (cmd.listen3 && second_argument != dkb_pkg::SELF_TEST)
        begin
            addr_next = first_argument[3:0];
            // handler only takes ids 1..3; special codes leave it alone
            if (second_argument[7:2] == '0 && second_argument[1:0] != 2'b00)
            begin
                handler_next = second_argument[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            len_reg     <= dkb_pkg::REPLY_NONE;
            b0_reg      <= '0;
            b1_reg      <= '0;
            addr_reg    <= dkb_pkg::DEFAULT_ADDR;
            handler_reg <= dkb_pkg::DEFAULT_HANDLER;
        end
        else
        begin
            done_reg    <= done_next;
            len_reg     <= len_next;
            b0_reg      <= b0_next;
            b1_reg      <= b1_next;
            addr_reg    <= addr_next;
            handler_reg <= handler_next;
        end
    end

    // power key pressed comes back doubled; anything else is padded with ff
    assign power_key = (stat.data == {1'b0, dkb_pkg::POWER_KEY});

    assign done         = done_reg;
    assign reply_length = stat.popped ? dkb_pkg::REPLY_TWO : len_reg;
    assign reply_first  = stat.popped ? stat.data : b0_reg;
    assign reply_second = stat.popped ? (power_key ? stat.data : dkb_pkg::FILL_BYTE) : b1_reg;
    assign data_pending = stat.pending;

endmodule

// ===== src/dkb_cmd_decode.sv =====
module dkb_cmd_decode
(
    input  logic              valid,
    input  logic              action,
    input  logic [7:0]        command_byte,
    output dkb_pkg::cmd_t     cmd
);

    dkb_pkg::cmd_kind_t kind;
    logic [1:0]         regn;

    assign kind = dkb_pkg::cmd_kind_t'(command_byte[3:2]);
    assign regn = command_byte[1:0];

    always_comb
    begin
        cmd = '0;
        if (valid)
        begin
            if (!action)
            begin
                cmd.push = 1'b1;
            end
            else if (command_byte[3:0] == dkb_pkg::FLUSH_NIBBLE)
            begin
                cmd.flush = 1'b1;
            end
            else
            begin
                unique case (kind)
                    dkb_pkg::KIND_LISTEN:
                    begin
                        cmd.listen3 = (regn == dkb_pkg::REG3);
                    end
                    dkb_pkg::KIND_TALK:
                    begin
                        cmd.pop   = (regn == dkb_pkg::REG0);
                        cmd.talk2 = (regn == dkb_pkg::REG2);
                        cmd.talk3 = (regn == dkb_pkg::REG3);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== src/dkb_code_fifo.sv =====
module dkb_code_fifo
#(
    parameter int FIFO_DEPTH = dkb_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dkb_pkg::cmd_t        cmd,
    input  logic [7:0]           wr_data,
    output dkb_pkg::fifo_stat_t  stat
);

    localparam int IDX_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             popped_reg, popped_next;
    logic             full, empty, do_push, do_pop;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = cmd.push && !full;
    assign do_pop  = cmd.pop && !empty;

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        popped_next = do_pop;
        if (cmd.flush)
        begin
            rd_idx_next = '0;
            wr_idx_next = '0;
            count_next  = '0;
        end
        else if (do_push)
        begin
            wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (do_pop)
        begin
            rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
            popped_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
            popped_reg <= popped_next;
        end
    end

    // one write port, one registered read port at the head
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_idx_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    assign stat.popped  = popped_reg;
    assign stat.pending = !empty;
    assign stat.data    = rd_data_reg;

endmodule

// ===== src/dkb_checker.sv =====
`include "desktop_bus_keyboard_device_unit_assert.svh"

module dkb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       action,
    input logic [7:0] command_byte,
    input logic       done,
    input logic [1:0] reply_length,
    input logic [7:0] reply_first,
    input logic [7:0] reply_second,
    input logic       data_pending
);

    logic accepted;
    logic flush_cmd;
    logic talk2_cmd;
    logic flush_seen;
    logic talk2_seen;

    assign accepted   = start && !busy;
    assign flush_cmd  = accepted && action && (command_byte[3:0] == dkb_pkg::FLUSH_NIBBLE);
    assign talk2_cmd  = accepted && action
                        && (command_byte[3:2] == dkb_pkg::KIND_TALK)
                        && (command_byte[1:0] == dkb_pkg::REG2);
    assign flush_seen = !data_pending && (reply_length == dkb_pkg::REPLY_NONE);
    assign talk2_seen = (reply_length == dkb_pkg::REPLY_TWO)
                        && (reply_first == dkb_pkg::LED_HI)
                        && (reply_second == dkb_pkg::LED_LO);

    // one result per transaction, in the cycle after
    `DKB_ASSERT_NEXT(a_result_follows, clk, rst_n, accepted, done)
    `DKB_ASSERT_IMPLY(a_no_orphan_result, clk, rst_n, done, $past(accepted))
    // flush empties the queue and gives no reply
    `DKB_ASSERT_NEXT(a_flush_empties, clk, rst_n, flush_cmd, flush_seen)
    // talk register 2 reports the fixed LED word
    `DKB_ASSERT_NEXT(a_talk2_word, clk, rst_n, talk2_cmd, talk2_seen)

endmodule

bind desktop_bus_keyboard_device_unit dkb_checker u_dkb_checker (.*);
